>>> rtl/dga_pkg.sv
// Shared constants and types for the diagonal gather address generator.
// No dependencies.
package dga_pkg;

    // index / address word
    localparam int IDX_W      = 48;
    // divider: quotient bits resolved per pipeline stage
    localparam int DIV_STEPS  = 8;
    localparam int DIV_STAGES = IDX_W / DIV_STEPS;

    // configuration register widths
    localparam int RANK_W   = 3;
    localparam int AXIS_W   = 4;
    localparam int OFFSET_W = 9;
    localparam int DIMS_W   = 48;

    // APB port
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;

    // register index, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_INPUT_RANK  = 3'd0,
        REG_AXIS_FIRST  = 3'd1,
        REG_AXIS_SECOND = 3'd2,
        REG_DIAG_OFFSET = 3'd3,
        REG_IN_DIMS     = 3'd4,
        REG_OUT_DIMS    = 3'd5
    } t_reg_idx;

endpackage

>>> rtl/dga_div_stage.sv
// One stage of the pipelined mixed-radix divider: DIV_STEPS restoring steps.
// Depends on dga_pkg.
module dga_div_stage import dga_pkg::*; #(
    parameter int DIM_BITS = 8,
    parameter int NC       = 5,
    parameter int UNIT     = 0,
    parameter bit CLEAR    = 1'b0,
    parameter bit LAST     = 1'b0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [IDX_W-1:0]             i_quot,
    input  logic [DIM_BITS-1:0]          i_rem,
    input  logic [NC-1:0][DIM_BITS-1:0]  i_coords,
    input  logic [DIM_BITS-1:0]          i_divisor,
    output logic                         o_valid,
    output logic [IDX_W-1:0]             o_quot,
    output logic [DIM_BITS-1:0]          o_rem,
    output logic [NC-1:0][DIM_BITS-1:0]  o_coords
);

    logic                        r_valid;
    logic [IDX_W-1:0]            r_quot,   n_quot;
    logic [DIM_BITS-1:0]         r_rem,    n_rem;
    logic [NC-1:0][DIM_BITS-1:0] r_coords, n_coords;
    logic [DIM_BITS:0]           rx;

    // shift-subtract steps; remainder stays below the divisor
    always_comb begin
        n_rem  = CLEAR ? '0 : i_rem;
        n_quot = i_quot;
        rx     = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            rx     = {n_rem, n_quot[IDX_W-1]};
            n_quot = {n_quot[IDX_W-2:0], 1'b0};
            if (rx >= {1'b0, i_divisor}) begin
                rx        = rx - {1'b0, i_divisor};
                n_quot[0] = 1'b1;
            end
            n_rem = rx[DIM_BITS-1:0];
        end
        n_coords = i_coords;
        if (LAST) begin
            n_coords[UNIT] = n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot   <= n_quot;
        r_rem    <= n_rem;
        r_coords <= n_coords;
    end

    assign o_valid  = r_valid;
    assign o_quot   = r_quot;
    assign o_rem    = r_rem;
    assign o_coords = r_coords;

endmodule

>>> rtl/dga_insert.sv
// Diagonal insertion stage: axis normalization, offset, coordinate placement.
// Depends on dga_pkg.
module dga_insert import dga_pkg::*; #(
    parameter int MAX_RANK = 6,
    parameter int DIM_BITS = 8,
    parameter int NC       = 5,
    parameter int RW       = 3,
    parameter int VW       = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [IDX_W-1:0]              i_quot,
    input  logic [NC-1:0][DIM_BITS-1:0]   i_coords,
    input  logic [RW-1:0]                 i_rank,
    input  logic [AXIS_W-1:0]             i_axis_first,
    input  logic [AXIS_W-1:0]             i_axis_second,
    input  logic [OFFSET_W-1:0]           i_offset,
    input  logic                          i_cfg_zero,
    output logic                          o_valid,
    output logic                          o_oor,
    output logic [MAX_RANK-1:0][VW-1:0]   o_vals
);

    logic                        r_valid;
    logic                        r_oor,  n_oor;
    logic [MAX_RANK-1:0][VW-1:0] r_vals, n_vals;

    logic [VW-1:0] l0 [MAX_RANK];
    logic [VW-1:0] l1 [MAX_RANK];
    logic [VW-1:0] l2 [MAX_RANK];
    logic [VW-1:0] t, tm, va, vb;
    int rk, ord, a1, a2, lo, hi, p1, p2, sh, off, mag;

    function automatic int norm_axis(input logic [AXIS_W-1:0] ax, input int rank);
        int a;
        a = int'(signed'(ax));
        if (a < 0) a = a + rank;
        if (a < 0) a = 0;
        if (a > rank - 1) a = rank - 1;
        return a;
    endfunction

    always_comb begin
        rk  = int'(i_rank);
        ord = rk - 1;
        a1  = norm_axis(i_axis_first, rk);
        a2  = norm_axis(i_axis_second, rk);
        lo  = (a1 < a2) ? a1 : a2;
        hi  = (a1 < a2) ? a2 : a1;

        // diagonal position and its offset copy
        off = int'(signed'(i_offset));
        mag = (off < 0) ? -off : off;
        t   = VW'(i_coords[0]);
        tm  = t + VW'(mag);
        va  = t;
        vb  = t;
        if (off > 0) begin
            if (a1 < a2) vb = tm;
            else         va = tm;
        end else if (off < 0) begin
            if (a1 < a2) va = tm;
            else         vb = tm;
        end

        // leading output coordinates (divider order is reversed)
        for (int i = 0; i < MAX_RANK; i++) begin
            l0[i] = '0;
            if (i < ord - 1) l0[i] = VW'(i_coords[ord - 1 - i]);
        end

        // first insertion, clamped to append
        p1 = (lo > ord - 1) ? ord - 1 : lo;
        for (int i = 0; i < MAX_RANK; i++) begin
            if (i < p1)       l1[i] = l0[i];
            else if (i == p1) l1[i] = va;
            else              l1[i] = l0[i - 1];
        end

        // second insertion
        p2 = (hi > ord) ? ord : hi;
        for (int i = 0; i < MAX_RANK; i++) begin
            if (i < p2)       l2[i] = l1[i];
            else if (i == p2) l2[i] = vb;
            else              l2[i] = l1[i - 1];
        end

        // right-align so the last coordinate sits at the last position
        sh = MAX_RANK - rk;
        for (int p = 0; p < MAX_RANK; p++) begin
            n_vals[p] = '0;
            if (p >= sh) n_vals[p] = l2[p - sh];
        end

        // out of range: quotient left over, or a zero output dimension
        n_oor = (i_quot != '0) || i_cfg_zero;
        if (n_oor) n_vals = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oor  <= n_oor;
        r_vals <= n_vals;
    end

    assign o_valid = r_valid;
    assign o_oor   = r_oor;
    assign o_vals  = r_vals;

endmodule

>>> rtl/dga_mac_stage.sv
// One Horner step of the input address: acc * dim + coordinate.
// Depends on dga_pkg.
module dga_mac_stage import dga_pkg::*; #(
    parameter int MAX_RANK = 6,
    parameter int DIM_BITS = 8,
    parameter int VW       = 10,
    parameter int POS      = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_oor,
    input  logic [IDX_W-1:0]              i_acc,
    input  logic [MAX_RANK-1:0][VW-1:0]   i_vals,
    input  logic [DIM_BITS-1:0]           i_dim,
    output logic                          o_valid,
    output logic                          o_oor,
    output logic [IDX_W-1:0]              o_acc,
    output logic [MAX_RANK-1:0][VW-1:0]   o_vals
);

    logic                        r_valid;
    logic                        r_oor;
    logic [IDX_W-1:0]            r_acc, n_acc;
    logic [MAX_RANK-1:0][VW-1:0] r_vals;
    logic [IDX_W+DIM_BITS-1:0]   prod;

    // product wraps to the address width
    always_comb begin
        prod  = i_acc * i_dim;
        n_acc = prod[IDX_W-1:0] + IDX_W'(i_vals[POS]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oor  <= i_oor;
        r_acc  <= n_acc;
        r_vals <= i_vals;
    end

    assign o_valid = r_valid;
    assign o_oor   = r_oor;
    assign o_acc   = r_acc;
    assign o_vals  = r_vals;

endmodule

>>> rtl/diagonal_gather_address.sv
// Diagonal gather address generator, top level with APB register file.
// Pipeline from start to o_valid:
//   six divider stages per output dimension, one insertion stage, one MAC stage per rank.
// Throughput: one transfer per cycle; busy stays low and o_valid marks each result for a single cycle.
// Reset (synchronous, active low) empties the pipeline and loads register defaults.
// Depends on dga_pkg, dga_div_stage, dga_insert, dga_mac_stage.
module diagonal_gather_address import dga_pkg::*; #(
    parameter int MAX_RANK = 6,
    parameter int DIM_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [IDX_W-1:0]   i_out_index,
    output logic               busy,
    output logic               o_valid,
    output logic [IDX_W-1:0]   o_in_address,
    output logic               o_out_of_range,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int NC    = MAX_RANK - 1;
    localparam int RW    = $clog2(MAX_RANK + 1);
    localparam int VW    = ((DIM_BITS > OFFSET_W) ? DIM_BITS : OFFSET_W) + 1;
    localparam int NDIV  = NC * DIV_STAGES;
    localparam int PK_W  = MAX_RANK * DIM_BITS;
    localparam int EXT_W = (PK_W > DIMS_W) ? PK_W : DIMS_W;

    // configuration registers
    logic [RANK_W-1:0]   r_input_rank;
    logic [AXIS_W-1:0]   r_axis_first;
    logic [AXIS_W-1:0]   r_axis_second;
    logic [OFFSET_W-1:0] r_diag_offset;
    logic [DIMS_W-1:0]   r_in_dims;
    logic [DIMS_W-1:0]   r_out_dims;
    t_reg_idx            reg_idx;

    assign reg_idx = t_reg_idx'(paddr[5:3]);
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_rank  <= RANK_W'(2);
            r_axis_first  <= '0;
            r_axis_second <= AXIS_W'(1);
            r_diag_offset <= '0;
            r_in_dims     <= '0;
            r_out_dims    <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_INPUT_RANK:  r_input_rank  <= pwdata[RANK_W-1:0];
                REG_AXIS_FIRST:  r_axis_first  <= pwdata[AXIS_W-1:0];
                REG_AXIS_SECOND: r_axis_second <= pwdata[AXIS_W-1:0];
                REG_DIAG_OFFSET: r_diag_offset <= pwdata[OFFSET_W-1:0];
                REG_IN_DIMS:     r_in_dims     <= pwdata[DIMS_W-1:0];
                REG_OUT_DIMS:    r_out_dims    <= pwdata[DIMS_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_INPUT_RANK:  prdata = PDATA_W'(r_input_rank);
            REG_AXIS_FIRST:  prdata = PDATA_W'(r_axis_first);
            REG_AXIS_SECOND: prdata = PDATA_W'(r_axis_second);
            REG_DIAG_OFFSET: prdata = PDATA_W'(r_diag_offset);
            REG_IN_DIMS:     prdata = PDATA_W'(r_in_dims);
            REG_OUT_DIMS:    prdata = PDATA_W'(r_out_dims);
            default:         prdata = '0;
        endcase
    end

    // shape decode, static while transfers are in flight: a user duty, not enforced
    logic [EXT_W-1:0]    in_ext, out_ext;
    logic [DIM_BITS-1:0] idim [MAX_RANK];
    logic [DIM_BITS-1:0] odim [MAX_RANK];
    logic [DIM_BITS-1:0] divisor [NC];
    logic [DIM_BITS-1:0] adim [MAX_RANK];
    logic [RW-1:0]       rank;
    logic                cfg_zero;
    int                  rk;

    assign in_ext  = EXT_W'(r_in_dims);
    assign out_ext = EXT_W'(r_out_dims);

    for (genvar i = 0; i < MAX_RANK; i++) begin : g_dims
        assign idim[i] = in_ext[(MAX_RANK-1-i)*DIM_BITS +: DIM_BITS];
        assign odim[i] = out_ext[(MAX_RANK-1-i)*DIM_BITS +: DIM_BITS];
    end

    always_comb begin
        rk = int'(r_input_rank);
        if (rk < 2)        rk = 2;
        if (rk > MAX_RANK) rk = MAX_RANK;
        rank = RW'(rk);
        // divider unit u peels off output dimension ord-1-u
        for (int u = 0; u < NC; u++) begin
            divisor[u] = DIM_BITS'(1);
            if (u < rk - 1) divisor[u] = odim[rk - 2 - u];
        end
        cfg_zero = 1'b0;
        for (int k = 0; k < NC; k++) begin
            if (k < rk - 1 && odim[k] == '0) cfg_zero = 1'b1;
        end
        // input dims right-aligned like the coordinates
        for (int p = 0; p < MAX_RANK; p++) begin
            adim[p] = '0;
            if (p >= MAX_RANK - rk) adim[p] = idim[p - (MAX_RANK - rk)];
        end
    end

    // divider chain
    logic                        dv_valid  [NDIV+1];
    logic [IDX_W-1:0]            dv_quot   [NDIV+1];
    logic [DIM_BITS-1:0]         dv_rem    [NDIV+1];
    logic [NC-1:0][DIM_BITS-1:0] dv_coords [NDIV+1];

    assign dv_valid[0]  = start && !busy;
    assign dv_quot[0]   = i_out_index;
    assign dv_rem[0]    = '0;
    assign dv_coords[0] = '0;

    for (genvar s = 0; s < NDIV; s++) begin : g_div
        dga_div_stage #(
            .DIM_BITS (DIM_BITS),
            .NC       (NC),
            .UNIT     (s / DIV_STAGES),
            .CLEAR    ((s % DIV_STAGES) == 0),
            .LAST     ((s % DIV_STAGES) == DIV_STAGES - 1)
        ) u_div (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (dv_valid[s]),
            .i_quot    (dv_quot[s]),
            .i_rem     (dv_rem[s]),
            .i_coords  (dv_coords[s]),
            .i_divisor (divisor[s / DIV_STAGES]),
            .o_valid   (dv_valid[s+1]),
            .o_quot    (dv_quot[s+1]),
            .o_rem     (dv_rem[s+1]),
            .o_coords  (dv_coords[s+1])
        );
    end

    // insertion of the diagonal coordinates
    logic                        mc_valid [MAX_RANK+1];
    logic                        mc_oor   [MAX_RANK+1];
    logic [IDX_W-1:0]            mc_acc   [MAX_RANK+1];
    logic [MAX_RANK-1:0][VW-1:0] mc_vals  [MAX_RANK+1];

    dga_insert #(
        .MAX_RANK (MAX_RANK),
        .DIM_BITS (DIM_BITS),
        .NC       (NC),
        .RW       (RW),
        .VW       (VW)
    ) u_insert (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (dv_valid[NDIV]),
        .i_quot        (dv_quot[NDIV]),
        .i_coords      (dv_coords[NDIV]),
        .i_rank        (rank),
        .i_axis_first  (r_axis_first),
        .i_axis_second (r_axis_second),
        .i_offset      (r_diag_offset),
        .i_cfg_zero    (cfg_zero),
        .o_valid       (mc_valid[0]),
        .o_oor         (mc_oor[0]),
        .o_vals        (mc_vals[0])
    );

    assign mc_acc[0] = '0;

    // Horner evaluation of the input address
    for (genvar p = 0; p < MAX_RANK; p++) begin : g_mac
        dga_mac_stage #(
            .MAX_RANK (MAX_RANK),
            .DIM_BITS (DIM_BITS),
            .VW       (VW),
            .POS      (p)
        ) u_mac (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (mc_valid[p]),
            .i_oor   (mc_oor[p]),
            .i_acc   (mc_acc[p]),
            .i_vals  (mc_vals[p]),
            .i_dim   (adim[p]),
            .o_valid (mc_valid[p+1]),
            .o_oor   (mc_oor[p+1]),
            .o_acc   (mc_acc[p+1]),
            .o_vals  (mc_vals[p+1])
        );
    end

    assign o_valid        = mc_valid[MAX_RANK];
    assign o_out_of_range = mc_oor[MAX_RANK];
    assign o_in_address   = mc_acc[MAX_RANK];

endmodule

>>> rtl/dga_checker.sv
// Port-level checks for the diagonal gather address generator, bound to the top.
// Depends on dga_pkg and diagonal_gather_address.
module dga_checker import dga_pkg::*; #(
    parameter int MAX_RANK = 6
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_valid,
    input logic [IDX_W-1:0] o_in_address,
    input logic             o_out_of_range
);

    localparam int LAT = (MAX_RANK - 1) * DIV_STAGES + 1 + MAX_RANK;

    // every accepted transfer gives a result on o_valid
    a_start_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_valid)
        else $error("accepted transfer produced no result");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without matching transfer");

    // out-of-range results carry a zero address
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> o_in_address == '0)
        else $error("out-of-range result with nonzero address");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy asserted");

endmodule

bind diagonal_gather_address dga_checker #(
    .MAX_RANK (MAX_RANK)
) u_dga_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_in_address   (o_in_address),
    .o_out_of_range (o_out_of_range)
);

>>> dv/tb_diagonal_gather_address.sv
// Self-checking testbench for diagonal_gather_address: random and directed output
// indices under several register settings, with an address predictor per transfer.
// Depends on dga_pkg and the diagonal_gather_address RTL.
module tb_diagonal_gather_address;
    import dga_pkg::*;

    localparam int RANK_MAX   = 6;
    localparam int PIPE_DEPTH = 40;
    localparam int LIMIT      = 400000;

    typedef struct {
        logic [IDX_W-1:0] addr;
        logic             oor;
    } t_gather;

    // Expected gather addresses plus a private copy of the register file
    class gather_board;
        logic [2:0]      rank_reg;
        logic [3:0]      ax1_reg;
        logic [3:0]      ax2_reg;
        logic [8:0]      offs_reg;
        logic [47:0]     in_dims;
        logic [47:0]     out_dims;
        t_gather         pending[$];
        int              errors;

        function void reset_regs();
            rank_reg = 3'd2;
            ax1_reg  = 4'd0;
            ax2_reg  = 4'd1;
            offs_reg = 9'd0;
            in_dims  = '0;
            out_dims = '0;
        endfunction

        function void set_reg(t_reg_idx r, logic [63:0] v);
            case (r)
                REG_INPUT_RANK:  rank_reg = v[2:0];
                REG_AXIS_FIRST:  ax1_reg  = v[3:0];
                REG_AXIS_SECOND: ax2_reg  = v[3:0];
                REG_DIAG_OFFSET: offs_reg = v[8:0];
                REG_IN_DIMS:     in_dims  = v[47:0];
                REG_OUT_DIMS:    out_dims = v[47:0];
                default: ;
            endcase
        endfunction

        function int eff_rank();
            int r;
            r = int'(rank_reg);
            if (r < 2) r = 2;
            if (r > RANK_MAX) r = RANK_MAX;
            return r;
        endfunction

        function logic [63:0] dim_of(logic [47:0] packed_dims, int k);
            return 64'(packed_dims >> ((RANK_MAX - 1 - k) * 8)) & 64'hFF;
        endfunction

        // number of output elements
        function logic [63:0] elem_count();
            logic [63:0] c;
            c = 1;
            for (int k = 0; k < eff_rank() - 1; k++) c = c * dim_of(out_dims, k);
            return c;
        endfunction

        function int norm_axis(logic [3:0] ax, int r);
            int a;
            a = int'($signed(ax));
            if (a < 0) a += r;
            if (a < 0) a = 0;
            if (a > r - 1) a = r - 1;
            return a;
        endfunction

        // insert v at position p of the coordinate list, appending past the end
        function void insert_coord(ref logic [63:0] lst[8], ref int len, input int p,
                                   input logic [63:0] v);
            if (p > len) p = len;
            for (int k = len; k > p; k--) lst[k] = lst[k-1];
            lst[p] = v;
            len++;
        endfunction

        function t_gather gather_addr(logic [IDX_W-1:0] idx);
            t_gather     g;
            logic [63:0] coord[8];
            logic [63:0] lst[8];
            logic [63:0] rem, t, mag, va, vb, addr, stride;
            int          r, ord, len, a1, a2, lo, hi, offs;
            r   = eff_rank();
            ord = r - 1;
            g.addr = '0;
            g.oor  = 1'b1;
            if (64'(idx) >= elem_count()) return g;
            rem = 64'(idx);
            for (int k = ord - 1; k >= 0; k--) begin
                coord[k] = rem % dim_of(out_dims, k);
                rem      = rem / dim_of(out_dims, k);
            end
            t   = coord[ord-1];
            len = 0;
            for (int k = 0; k < ord - 1; k++) lst[len++] = coord[k];
            a1   = norm_axis(ax1_reg, r);
            a2   = norm_axis(ax2_reg, r);
            lo   = (a1 < a2) ? a1 : a2;
            hi   = (a1 < a2) ? a2 : a1;
            offs = int'($signed(offs_reg));
            mag  = 64'((offs < 0) ? -offs : offs);
            va   = t;
            vb   = t;
            // offset lands on the second axis when positive, the first when negative
            if ((offs > 0) == (a1 < a2) && offs != 0) vb = t + mag;
            else if (offs != 0) va = t + mag;
            insert_coord(lst, len, lo, va);
            insert_coord(lst, len, hi, vb);
            addr   = 0;
            stride = 1;
            for (int k = r - 1; k >= 0; k--) begin
                addr   = addr + lst[k] * stride;
                stride = stride * dim_of(in_dims, k);
            end
            g.addr = addr[IDX_W-1:0];
            g.oor  = 1'b0;
            return g;
        endfunction

        function void note_index(logic [IDX_W-1:0] idx);
            pending = {pending, gather_addr(idx)};
        endfunction

        function void check_result(logic [IDX_W-1:0] addr, logic oor);
            t_gather e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result addr=%h oor=%b", $time, addr, oor);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (e.addr !== addr) begin
                $display("%0t: in_address expected %h actual %h", $time, e.addr, addr);
                errors++;
            end
            if (e.oor !== oor) begin
                $display("%0t: out_of_range expected %b actual %b", $time, e.oor, oor);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic [IDX_W-1:0]   i_out_index;
    logic               busy;
    logic               o_valid;
    logic [IDX_W-1:0]   o_in_address;
    logic               o_out_of_range;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    gather_board board;
    int          cycles;

    diagonal_gather_address dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_out_index    (i_out_index),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_in_address   (o_in_address),
        .o_out_of_range (o_out_of_range),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // input transfers and results, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) board.note_index(i_out_index);
        if (i_rst_n && o_valid) board.check_result(o_in_address, o_out_of_range);
    end

    task automatic write_reg(t_reg_idx r, logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 3'b000};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(r, v);
    endtask

    task automatic write_setup(logic [2:0] rk, logic [3:0] a1, logic [3:0] a2,
                               logic [8:0] offs, logic [47:0] idims, logic [47:0] odims);
        write_reg(REG_INPUT_RANK, 64'(rk));
        write_reg(REG_AXIS_FIRST, 64'(a1));
        write_reg(REG_AXIS_SECOND, 64'(a2));
        write_reg(REG_DIAG_OFFSET, 64'(offs));
        write_reg(REG_IN_DIMS, 64'(idims));
        write_reg(REG_OUT_DIMS, 64'(odims));
    endtask

    task automatic send_index(logic [IDX_W-1:0] idx);
        start       <= 1'b1;
        i_out_index <= idx;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic sender_gap(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // let every pending transfer come out, then the pipeline settle
    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH) @(posedge i_clk);
    endtask

    function automatic logic [47:0] rand_dims();
        logic [47:0] d;
        int          mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < RANK_MAX; k++) begin
            d = d << 8;
            if (mode == 0 && $urandom_range(0, 5) == 0) d[7:0] = 8'd0;
            else if (mode < 4) d[7:0] = 8'($urandom_range(1, 255));
            else d[7:0] = 8'($urandom_range(1, 7));
        end
        return d;
    endfunction

    function automatic logic [IDX_W-1:0] rand_index(logic [63:0] cnt);
        logic [63:0] w;
        int          sel;
        w   = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (cnt != 0 && sel < 8) return IDX_W'(w % cnt);
        if (sel == 8) return IDX_W'(cnt + 64'($urandom_range(0, 3)));
        return w[IDX_W-1:0];
    endfunction

    // extremes of the index for the current setting
    task automatic send_edges();
        logic [63:0] cnt;
        cnt = board.elem_count();
        send_index('0);
        send_index(IDX_W'(cnt - 1));
        send_index(IDX_W'(cnt));
        send_index({IDX_W{1'b1}});
        drain();
    endtask

    initial begin
        logic [63:0] cnt;
        board       = new();
        board.reset_regs();
        board.errors = 0;
        cycles      = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_out_index = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: zero output dims, so everything is out of range
        send_index('0);
        send_index({IDX_W{1'b1}});
        drain();
        // rank above max, axes at both register extremes, full dims
        write_setup(3'd7, 4'h8, 4'h7, 9'd255, {6{8'hFF}}, {6{8'hFF}});
        send_edges();
        // rank below min, equal axes, most negative offset
        write_setup(3'd0, 4'd3, 4'd3, 9'h100, 48'h0305_0700_0000, 48'h0604_0000_0000);
        send_edges();
        // negative axes in reverse order, negative offset
        write_setup(3'd4, 4'hF, 4'hD, 9'h1FF, 48'h0506_0708_0000, 48'h0302_0400_0000);
        send_edges();
        // equal axes, zero offset, one zero output dim
        write_setup(3'd6, 4'd2, 4'd2, 9'd0, 48'h0203_0405_0607, 48'h0203_0004_0500);
        send_edges();

        // random settings, each with a run of random indices
        for (int ph = 0; ph < 12; ph++) begin
            write_setup(3'($urandom), 4'($urandom), 4'($urandom), 9'($urandom),
                        rand_dims(), rand_dims());
            cnt = board.elem_count();
            for (int i = 0; i < 125; i++) begin
                if (ph < 10 && $urandom_range(0, 5) == 0 && i > 20)
                    sender_gap($urandom_range(1, 16));
                send_index(rand_index(cnt));
            end
            drain();
        end

        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
